>>> hw/rtl/ans_pkg.sv
// Shared types and constants of the Annex B NAL unit splitter.
// Used by the parser, the result queue, its cells and the top level.
`default_nettype none

package ans_pkg;

	// Held tail of an open unit: the last byte and up to three trailing zeros.
	localparam int HOLD     = 4;
	localparam int HCNT_W   = $clog2(HOLD + 1);
	// One byte can release the whole tail plus itself.
	localparam int MAX_PUSH = HOLD + 1;
	localparam int PCNT_W   = $clog2(MAX_PUSH + 1);
	localparam int PIDX_W   = $clog2(MAX_PUSH);
	// Result queue. With the output always ready the fill never passes five,
	// so ten entries keep the input open on every cycle.
	localparam int QDEPTH   = 10;
	localparam int CNT_W    = $clog2(QDEPTH + 1);

	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [4:0] TYPE_MASK  = 5'h1f;
	localparam logic [4:0] TYPE_IDR   = 5'd5;
	localparam logic [4:0] TYPE_SPS   = 5'd7;
	localparam logic [4:0] TYPE_PPS   = 5'd8;

	typedef struct packed {
		logic [7:0] nal_byte;
		logic       first;
		logic       last;
		logic [4:0] unit_type;
	} entry_t;

	// Results released by one input byte, in order, from index 0.
	typedef struct packed {
		logic [PCNT_W-1:0]               count;
		entry_t [MAX_PUSH-1:0]           data;
	} push_t;

	typedef struct packed {
		logic valid;
		logic room;
	} q_stat_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_LOAD
	} cell_op_t;

endpackage

`default_nettype wire

>>> hw/rtl/ans_in_if.sv
// Input channel of the splitter: one stream byte per beat.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface ans_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       end_of_stream;

	modport source (output valid, output stream_byte, output end_of_stream, input ready);
	modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ans_out_if.sv
// Output channel of the splitter: one NAL payload byte with its marks per beat.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface ans_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] nal_byte;
	logic       first_of_unit;
	logic       last_of_unit;
	logic [4:0] unit_type;
	logic       is_keyframe;
	logic       is_parameter_set;

	modport source (
		output valid, output nal_byte, output first_of_unit, output last_of_unit,
		output unit_type, output is_keyframe, output is_parameter_set, input ready
	);
	modport sink (
		input valid, input nal_byte, input first_of_unit, input last_of_unit,
		input unit_type, input is_keyframe, input is_parameter_set, output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/ans_cell.sv
// One cell of the result queue: holds one result, takes its neighbor's or a new one.
// Depends on ans_pkg.
`default_nettype none

module ans_cell (
	input  wire               clk,
	input  ans_pkg::cell_op_t op,
	input  ans_pkg::entry_t   nbr,
	input  ans_pkg::entry_t   load,
	output ans_pkg::entry_t   q
);
	import ans_pkg::*;

	entry_t data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_SHIFT: data_q <= nbr;
			CELL_LOAD:  data_q <= load;
			default:    data_q <= data_q;
		endcase
	end

	assign q = data_q;

endmodule

`default_nettype wire

>>> hw/rtl/ans_queue.sv
// Collapsing result queue built as a row of cells; cell 0 is the head.
// Depends on ans_pkg and ans_cell.
`default_nettype none

module ans_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  ans_pkg::push_t   push,
	input  wire              pop,
	output ans_pkg::entry_t  head,
	output ans_pkg::q_stat_t stat
);
	import ans_pkg::*;

	logic [CNT_W-1:0] count_q;
	entry_t           cell_q [QDEPTH];
	cell_op_t         op     [QDEPTH];
	entry_t           ld     [QDEPTH];

	// Each cell either keeps its entry, takes its upper neighbor's on a pop,
	// or is filled from the new results that land at its position.
	for (genvar g = 0; g < QDEPTH; g++) begin : g_cell
		logic [CNT_W-1:0] src;
		logic [CNT_W-1:0] widx;

		always_comb begin
			src  = CNT_W'(g) + CNT_W'(pop);
			widx = src - count_q;
			ld[g] = push.data[widx[PIDX_W-1:0]];
			if (src < count_q) begin
				op[g] = pop ? CELL_SHIFT : CELL_HOLD;
			end else if (widx < CNT_W'(push.count)) begin
				op[g] = CELL_LOAD;
			end else begin
				op[g] = CELL_HOLD;
			end
		end

		if (g == QDEPTH - 1) begin : g_top
			ans_cell u_cell (
				.clk  (clk),
				.op   (op[g]),
				.nbr  ('0),
				.load (ld[g]),
				.q    (cell_q[g])
			);
		end else begin : g_mid
			ans_cell u_cell (
				.clk  (clk),
				.op   (op[g]),
				.nbr  (cell_q[g+1]),
				.load (ld[g]),
				.q    (cell_q[g])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q - CNT_W'(pop) + CNT_W'(push.count);
		end
	end

	assign head       = cell_q[0];
	assign stat.valid = (count_q != '0);
	assign stat.room  = (count_q <= CNT_W'(QDEPTH - MAX_PUSH));

endmodule

`default_nettype wire

>>> hw/rtl/ans_parse.sv
// Start code parser: keeps the tail of the open unit and releases decided bytes.
// Depends on ans_pkg.
`default_nettype none

module ans_parse (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             take,
	input  wire [7:0]       stream_byte,
	input  wire             end_of_stream,
	output ans_pkg::push_t  push
);
	import ans_pkg::*;

	logic                  inside_q;
	logic                  hdr_q;
	logic [4:0]            type_q;
	logic [HCNT_W-1:0]     hcnt_q;
	logic [HOLD-1:0][7:0]  held_q;

	logic                  nxt_inside;
	logic                  nxt_hdr;
	logic [4:0]            nxt_type;
	logic [HCNT_W-1:0]     nxt_hcnt;
	logic [HOLD-1:0][7:0]  nxt_held;
	logic [PCNT_W-1:0]     emit_cnt;
	logic                  set_last;
	logic [4:0]            res_type;
	logic [HOLD:0][7:0]    bufv;

	always_comb begin
		logic [HCNT_W-1:0] n;
		logic [PCNT_W-1:0] m;
		logic [PCNT_W-1:0] k;
		logic [PCNT_W-1:0] keep;
		logic [PCNT_W-1:0] drop;
		logic [PCNT_W-1:0] rem;
		logic [PCNT_W-1:0] idx;
		logic              sc;
		logic              run;

		nxt_inside = inside_q;
		nxt_hdr    = hdr_q;
		nxt_type   = type_q;
		nxt_hcnt   = hcnt_q;
		nxt_held   = held_q;
		emit_cnt   = '0;
		set_last   = 1'b0;
		res_type   = type_q;
		sc         = 1'b0;
		run        = 1'b1;
		k          = '0;
		keep       = '0;
		drop       = '0;
		rem        = '0;
		idx        = '0;
		n          = (hcnt_q > HCNT_W'(HOLD)) ? HCNT_W'(HOLD) : hcnt_q;
		m          = PCNT_W'(n) + PCNT_W'(1);

		// Tail bytes followed by the incoming byte at position n.
		for (int i = 0; i < HOLD; i++) begin
			bufv[i] = (HCNT_W'(i) < n) ? held_q[i] : stream_byte;
		end
		bufv[HOLD] = stream_byte;

		if (!inside_q) begin
			// Outside a unit the count tracks trailing zeros, saturating at two.
			if (stream_byte == START_BYTE && hcnt_q >= HCNT_W'(2)) begin
				nxt_inside = 1'b1;
				nxt_hdr    = 1'b1;
				nxt_hcnt   = '0;
			end else if (stream_byte == ZERO_BYTE) begin
				nxt_hcnt = (hcnt_q >= HCNT_W'(2)) ? HCNT_W'(2) : hcnt_q + HCNT_W'(1);
			end else begin
				nxt_hcnt = '0;
			end
		end else begin
			if (n >= HCNT_W'(2) && stream_byte == START_BYTE) begin
				sc = (bufv[n - HCNT_W'(1)] == ZERO_BYTE) &&
				     (bufv[n - HCNT_W'(2)] == ZERO_BYTE);
			end
			if (sc) begin
				// Start code closes the unit; a third zero of the unit goes too.
				rem = PCNT_W'(n) - PCNT_W'(2);
				if (rem != '0) begin
					if (bufv[rem - PCNT_W'(1)] == ZERO_BYTE) begin
						rem = rem - PCNT_W'(1);
					end
				end
				emit_cnt = rem;
				set_last = 1'b1;
				nxt_hcnt = '0;
				nxt_hdr  = 1'b1;
			end else begin
				if (hdr_q && n == '0) begin
					nxt_type = stream_byte[4:0] & TYPE_MASK;
				end
				res_type = nxt_type;
				if (end_of_stream) begin
					emit_cnt = m;
					set_last = 1'b1;
				end else begin
					// Keep up to three trailing zeros and the byte just before them.
					for (int j = 0; j < MAX_PUSH; j++) begin
						if (PCNT_W'(j) < m) begin
							idx = m - PCNT_W'(1) - PCNT_W'(j);
							if (run && bufv[idx] == ZERO_BYTE) begin
								k = k + PCNT_W'(1);
							end else begin
								run = 1'b0;
							end
						end
					end
					keep = ((k > PCNT_W'(3)) ? PCNT_W'(3) : k) + PCNT_W'(1);
					if (keep > m) begin
						keep = m;
					end
					drop = m - keep;
					emit_cnt = drop;
					for (int i = 0; i < HOLD; i++) begin
						if (PCNT_W'(i) < keep) begin
							nxt_held[i] = bufv[drop + PCNT_W'(i)];
						end
					end
					nxt_hcnt = HCNT_W'(keep);
				end
				if (emit_cnt != '0) begin
					nxt_hdr = 1'b0;
				end
			end
		end

		// End of stream returns to the state before any start code.
		if (end_of_stream) begin
			nxt_inside = 1'b0;
			nxt_hdr    = 1'b0;
			nxt_type   = '0;
			nxt_hcnt   = '0;
		end
	end

	always_comb begin
		push.count = take ? emit_cnt : '0;
		for (int i = 0; i < MAX_PUSH; i++) begin
			push.data[i].nal_byte  = bufv[i];
			push.data[i].first     = hdr_q && (i == 0);
			push.data[i].last      = set_last && (PCNT_W'(i) == emit_cnt - PCNT_W'(1));
			push.data[i].unit_type = res_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			hdr_q    <= 1'b0;
			type_q   <= '0;
			hcnt_q   <= '0;
		end else if (take) begin
			inside_q <= nxt_inside;
			hdr_q    <= nxt_hdr;
			type_q   <= nxt_type;
			hcnt_q   <= nxt_hcnt;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			held_q <= nxt_held;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/annexb_nal_unit_splitter_top.sv
// Top level of the Annex B NAL unit splitter.
// Depends on ans_pkg, ans_in_if, ans_out_if, ans_parse and ans_queue.
//
// The byte_in channel takes one byte of an Annex B stream per beat, with
// end_of_stream set on the final byte. The nal_out channel gives one NAL
// payload byte per beat with first/last marks, the unit type and the keyframe
// and parameter-set flags; start codes and the bytes before the first one
// never appear. A beat on byte_in is accepted whenever the result queue has
// at least five free entries; one input beat may release up to five results,
// which leave at one per clock while nal_out is ready, through a ten-entry
// queue of cells. While nal_out is always ready the queue never holds more
// than five results, so byte_in takes one byte per clock with no gaps.
// A byte that is decided at once shows on nal_out in the cycle after it is
// accepted when the queue is empty, later behind older results; a byte that
// could still belong to a start code stays in the parser's four-byte tail
// until a later byte or end_of_stream settles it.
// When nal_out stalls, results wait in the queue and byte_in keeps taking
// beats until fewer than five entries are free. Reset empties the queue and
// returns the parser to the state before any start code.
`default_nettype none

module annexb_nal_unit_splitter_top (
	input  wire       clk,
	input  wire       arst_n,
	ans_in_if.sink    byte_in,
	ans_out_if.source nal_out
);
	import ans_pkg::*;

	logic    take;
	logic    pop;
	push_t   push;
	entry_t  head;
	q_stat_t stat;

	assign byte_in.ready = stat.room;
	assign take          = byte_in.valid && stat.room;
	assign pop           = stat.valid && nal_out.ready;

	ans_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.stream_byte   (byte_in.stream_byte),
		.end_of_stream (byte_in.end_of_stream),
		.push          (push)
	);

	ans_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	// Flags follow from the type of the head entry.
	assign nal_out.valid            = stat.valid;
	assign nal_out.nal_byte         = head.nal_byte;
	assign nal_out.first_of_unit    = head.first;
	assign nal_out.last_of_unit     = head.last;
	assign nal_out.unit_type        = head.unit_type;
	assign nal_out.is_keyframe      = (head.unit_type == TYPE_IDR);
	assign nal_out.is_parameter_set = (head.unit_type == TYPE_SPS) ||
	                                  (head.unit_type == TYPE_PPS);

	// Results pushed into the queue are visible on the next cycle.
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != '0) |=> stat.valid)
		else $error("pushed results did not reach the queue head");

	// After an end of stream the parser is outside any unit and emits nothing
	// for the next byte.
	a_eos_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(take && byte_in.end_of_stream) |=> (push.count == '0))
		else $error("parser emitted results right after end of stream");

	// The queue only runs empty by handing out its last entry.
	a_empty_by_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stat.valid) |-> $past(pop))
		else $error("result queue lost an entry");

endmodule

`default_nettype wire

>>> test/ans_nal_checker.sv
// Scoreboard for the Annex B NAL unit splitter: watches both channels and
// predicts every NAL payload beat. Depends on ans_pkg, ans_in_if and ans_out_if.
`default_nettype none

module ans_nal_checker
	import ans_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	ans_in_if    byte_mon,
	ans_out_if   nal_mon,
	input  logic wrap_up,
	output int   fail_count,
	output int   outstanding,
	output int   beats_checked,
	output int   units_seen
);

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic [4:0] utype;
		logic       key;
		logic       pset;
	} nal_beat_t;

	logic [7:0] tail_q [0:3];
	int         tail_n;
	bit         in_unit;
	bit         hdr_pending;
	logic [4:0] cur_type;
	nal_beat_t  awaited_nal [$];
	int         mismatches = 0;

	initial begin
		outstanding   = 0;
		beats_checked = 0;
		units_seen    = 0;
	end

	assign fail_count = mismatches + (wrap_up ? outstanding : 0);

	function automatic void clear_state();
		tail_n      = 0;
		in_unit     = 0;
		hdr_pending = 0;
		cur_type    = '0;
	endfunction

	function automatic void emit_nal(logic [7:0] b, bit last);
		nal_beat_t e;
		e.data  = b;
		e.first = hdr_pending;
		e.last  = last;
		e.utype = cur_type;
		e.key   = (cur_type == TYPE_IDR);
		e.pset  = (cur_type == TYPE_SPS) || (cur_type == TYPE_PPS);
		awaited_nal.insert(awaited_nal.size(), e);
		hdr_pending = 0;
	endfunction

	// The open unit keeps its last byte plus up to three trailing zeros, since
	// those zeros may still turn out to be part of the next start code.
	function automatic void predict_split(logic [7:0] b, bit eos);
		logic [7:0] tail [0:4];
		int n, k, keep, cut, rem;
		if (!in_unit) begin
			if (b == START_BYTE && tail_n >= 2) begin
				in_unit     = 1;
				hdr_pending = 1;
				tail_n      = 0;
			end else if (b == ZERO_BYTE) begin
				tail_n = (tail_n >= 2) ? 2 : tail_n + 1;
			end else begin
				tail_n = 0;
			end
			if (eos)
				clear_state();
			return;
		end
		n = tail_n;
		for (int i = 0; i < n; i++)
			tail[i] = tail_q[i];
		if (b == START_BYTE && n >= 2 && tail[n-1] == ZERO_BYTE && tail[n-2] == ZERO_BYTE) begin
			rem = n - 2;
			if (rem >= 1 && tail[rem-1] == ZERO_BYTE)
				rem--;
			for (int i = 0; i < rem; i++)
				emit_nal(tail[i], i + 1 == rem);
			tail_n      = 0;
			hdr_pending = 1;
			if (eos)
				clear_state();
			return;
		end
		if (hdr_pending && n == 0)
			cur_type = b[4:0];
		tail[n] = b;
		n++;
		if (eos) begin
			for (int i = 0; i < n; i++)
				emit_nal(tail[i], i + 1 == n);
			clear_state();
			return;
		end
		k = 0;
		while (k < n && tail[n-1-k] == ZERO_BYTE)
			k++;
		keep = ((k > 3) ? 3 : k) + 1;
		if (keep > n)
			keep = n;
		cut = n - keep;
		for (int i = 0; i < cut; i++)
			emit_nal(tail[i], 1'b0);
		for (int i = 0; i < keep; i++)
			tail_q[i] = tail[cut + i];
		tail_n = keep;
	endfunction

	function automatic void check_result();
		nal_beat_t got, want;
		got.data  = nal_mon.nal_byte;
		got.first = nal_mon.first_of_unit;
		got.last  = nal_mon.last_of_unit;
		got.utype = nal_mon.unit_type;
		got.key   = nal_mon.is_keyframe;
		got.pset  = nal_mon.is_parameter_set;
		beats_checked++;
		if (got.first)
			units_seen++;
		if (awaited_nal.size() == 0) begin
			if (mismatches < 10)
				$display("ERROR: unexpected NAL beat byte=%h first=%0b last=%0b type=%0d",
					got.data, got.first, got.last, got.utype);
			mismatches++;
			return;
		end
		want = awaited_nal.pop_front();
		if (got !== want) begin
			if (mismatches < 10)
				$display({"ERROR: NAL beat %0d: expected byte=%h first=%0b last=%0b type=%0d ",
					"key=%0b ps=%0b, got byte=%h first=%0b last=%0b type=%0d key=%0b ps=%0b"},
					beats_checked, want.data, want.first, want.last, want.utype, want.key,
					want.pset, got.data, got.first, got.last, got.utype, got.key, got.pset);
			mismatches++;
		end
	endfunction

	// Output beats are matched before the input beat of the same edge is
	// predicted; a byte can never show up in the cycle it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			awaited_nal.delete();
		end else begin
			if (nal_mon.valid && nal_mon.ready)
				check_result();
			if (byte_mon.valid && byte_mon.ready)
				predict_split(byte_mon.stream_byte, byte_mon.end_of_stream);
		end
		outstanding = awaited_nal.size();
	end

	always @(posedge wrap_up) begin
		if (awaited_nal.size() != 0)
			$display("ERROR: %0d predicted NAL bytes never appeared", awaited_nal.size());
	end

endmodule

`default_nettype wire

>>> test/tb.sv
// Top of the splitter testbench: clock, reset, byte stimulus and output stalls.
// Depends on ans_pkg, both channel interfaces, the splitter top and ans_nal_checker.
`default_nettype none

module tb
	import ans_pkg::*;
;

	logic clk;
	logic arst_n;
	logic wrap_up;
	int   fail_count;
	int   outstanding;
	int   beats_checked;
	int   units_seen;
	int   bytes_sent;
	int   burst_left;

	ans_in_if  byte_in_ch ();
	ans_out_if nal_out_ch ();

	annexb_nal_unit_splitter_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in_ch),
		.nal_out (nal_out_ch)
	);

	// The checker sees exactly what the block sees and keeps its own
	// expected NAL stream; this module only feeds bytes and gives the verdict.
	ans_nal_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_mon      (byte_in_ch),
		.nal_mon       (nal_out_ch),
		.wrap_up       (wrap_up),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.beats_checked (beats_checked),
		.units_seen    (units_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs. A correct run needs well under a
	// tenth of this even with every stall stretched to its longest.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// The receiver cycles through four stall styles in turn: always ready,
	// random stalls, a fixed periodic stall, and rare long stalls. The long
	// ones let the result queue fill so that byte_in has to back off.
	initial begin
		int tick;
		int stall_left;
		tick       = 0;
		stall_left = 0;
		nal_out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			tick++;
			case ((tick / 256) % 4)
				0: begin
					nal_out_ch.ready <= 1'b1;
				end
				1: begin
					nal_out_ch.ready <= ($urandom_range(0, 3) != 0);
				end
				2: begin
					nal_out_ch.ready <= ((tick % 11) >= 4);
				end
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						nal_out_ch.ready <= 1'b0;
					end else if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(3, 14);
						nal_out_ch.ready <= 1'b0;
					end else begin
						nal_out_ch.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Sends one byte as a beat. The sender works in bursts: when a burst runs
	// out it may drop valid before the next one starts. A zero-length gap keeps
	// valid high, so long stretches run without idling.
	task automatic put_byte(input logic [7:0] b, input logic eos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				byte_in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		byte_in_ch.valid         <= 1'b1;
		byte_in_ch.stream_byte   <= b;
		byte_in_ch.end_of_stream <= eos;
		@(posedge clk);
		while (!byte_in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Holds the input idle until every predicted NAL byte has left the block.
	task automatic drain_pause();
		byte_in_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	// Payload is biased toward zeros and 01 so that start-code look-alikes,
	// long zero runs and emulation-prevention bytes come up often.
	function automatic logic [7:0] payload_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return ZERO_BYTE;
		if (r < 45)
			return START_BYTE;
		if (r < 50)
			return 8'h03;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic put_start_code();
		if ($urandom_range(0, 2) == 0)
			put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(START_BYTE, 1'b0);
	endtask

	// One well-formed unit: start code, header byte and payload. Now and then
	// the unit is left empty, or ends in a run of zeros that reaches into the
	// next start code.
	task automatic put_unit();
		logic [4:0] t;
		int len;
		put_start_code();
		if ($urandom_range(0, 19) == 0)
			return;
		case ($urandom_range(0, 5))
			0:       t = TYPE_IDR;
			1:       t = TYPE_SPS;
			2:       t = TYPE_PPS;
			3:       t = 5'd1;
			default: t = 5'($urandom_range(0, 31));
		endcase
		put_byte({3'($urandom_range(0, 7)), t}, 1'b0);
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 10);
		repeat (len)
			put_byte(payload_byte(), 1'b0);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6))
				put_byte(ZERO_BYTE, 1'b0);
	endtask

	initial begin
		int w;
		int r;
		arst_n                   = 1'b0;
		wrap_up                  = 1'b0;
		bytes_sent               = 0;
		burst_left               = 0;
		byte_in_ch.valid         = 1'b0;
		byte_in_ch.stream_byte   = '0;
		byte_in_ch.end_of_stream = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed stream. Junk and a saturating zero run before the first
		// start code, an IDR unit closed by a four-byte start code, an empty
		// unit made only of stripped zeros, an SPS unit whose long zero run
		// keeps its first zero as payload, then a PPS unit flushed by end of
		// stream, and last a stream whose final byte completes a start code.
		put_byte(8'h55, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(START_BYTE, 1'b0);
		put_byte(8'hE5, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(START_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(START_BYTE, 1'b0);
		put_byte(8'h67, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(START_BYTE, 1'b0);
		put_byte(8'h08, 1'b0);
		put_byte(8'h80, 1'b1);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(ZERO_BYTE, 1'b0);
		put_byte(START_BYTE, 1'b1);
		drain_pause();

		// Random part: mostly well-formed units with random content, mixed
		// with noise, stream ends, broken start codes and drain pauses.
		while (bytes_sent < 360) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				put_unit();
			end else if (r < 80) begin
				repeat ($urandom_range(1, 6))
					put_byte(payload_byte(), ($urandom_range(0, 29) == 0));
			end else if (r < 88) begin
				if ($urandom_range(0, 2) == 0) begin
					put_byte(ZERO_BYTE, 1'b0);
					put_byte(ZERO_BYTE, 1'b0);
					put_byte(START_BYTE, 1'b1);
				end else begin
					put_byte(payload_byte(), 1'b1);
				end
				repeat ($urandom_range(0, 3))
					put_byte(8'($urandom_range(0, 255)), 1'b0);
			end else if (r < 92) begin
				drain_pause();
			end else begin
				// A start code cut short, then ordinary bytes.
				put_byte(ZERO_BYTE, 1'b0);
				if ($urandom_range(0, 1) == 0)
					put_byte(ZERO_BYTE, 1'b0);
				put_byte(8'($urandom_range(2, 255)), 1'b0);
				put_byte(START_BYTE, 1'b0);
			end
		end
		put_byte(8'($urandom_range(0, 255)), 1'b1);
		byte_in_ch.valid <= 1'b0;

		w = 0;
		while (outstanding != 0 && w < 20000) begin
			@(negedge clk);
			w++;
		end
		repeat (16) @(negedge clk);
		wrap_up <= 1'b1;
		@(negedge clk);

		$display("Run covered %0d stream bytes under shifting sender bursts and receiver stalls.",
			bytes_sent);
		$display("%0d NAL bytes were checked across %0d units.", beats_checked, units_seen);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
